@@ design/bcsa_pkg.sv @@
// Shared constants and types of the block cache slot allocator.
`timescale 1ns / 1ps

package bcsa_pkg;

  localparam int ENTRIES_DEF  = 512;
  localparam int TAG_BITS_DEF = 48;

  localparam int BLOCK_W  = 48;
  localparam int SLOT_W_O = 9;
  localparam int SECTOR_W = 56;
  localparam int SPB_W    = 9;

  localparam logic [SPB_W-1:0] SPB_RESET = 9'd4;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_ALLOC  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

endpackage

@@ design/bcsa_tag_scan.sv @@
// Tag memory with a sequential lookup that compares one stored tag per cycle.
`timescale 1ns / 1ps

module bcsa_tag_scan import bcsa_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int SLOT_W  = $clog2(ENTRIES),
  localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [TAG_BITS-1:0] tag,
  input  logic [CNT_W-1:0]    fill,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   wr_addr,
  output scan_stat_t          stat,
  output logic [SLOT_W-1:0]   match_idx
);

  logic [TAG_BITS-1:0] tag_mem [ENTRIES];
  logic [TAG_BITS-1:0] rd_data_r;
  logic                busy_r;
  logic [CNT_W-1:0]    issue_idx_r;
  logic                pend_vld_r;
  logic [SLOT_W-1:0]   pend_idx_r;
  logic                issue_more;
  logic                cmp_hit;

  // Only the filled prefix of the memory holds valid tags.
  assign issue_more = busy_r && (issue_idx_r < fill);
  assign cmp_hit    = pend_vld_r && (rd_data_r == tag);

  assign stat.hit  = cmp_hit;
  assign stat.done = busy_r && (cmp_hit || (!issue_more && !pend_vld_r));
  assign match_idx = pend_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_vld_r  <= 1'b0;
      issue_idx_r <= '0;
    end else if (start) begin
      busy_r      <= 1'b1;
      pend_vld_r  <= 1'b0;
      issue_idx_r <= '0;
    end else if (stat.done) begin
      busy_r     <= 1'b0;
      pend_vld_r <= 1'b0;
    end else if (busy_r) begin
      pend_vld_r <= issue_more;
      if (issue_more) begin
        issue_idx_r <= issue_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_more) begin
      pend_idx_r <= issue_idx_r[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= tag;
    end
    if (issue_more) begin
      rd_data_r <= tag_mem[issue_idx_r[SLOT_W-1:0]];
    end
  end

endmodule

@@ design/block_cache_slot_allocator.sv @@
// Top level of the block cache slot allocator: sequencer, allocation and result register.
`timescale 1ns / 1ps

// Slot manager of a fully associative disk block cache.
// Input channel (in_valid/in_ready, in_block_number): one requested block per
// transfer. Result channel (out_valid/out_ready): slot index, hit flag and the
// first sector to fetch (zero on a hit). Config channel (cfg_valid/cfg_ready,
// cfg_data): sectors per block, always ready; the user must write it only
// while idle, which the block itself does not enforce. A lookup reads the tag
// memory one entry per cycle through the filled slots. On a miss the scan
// runs through every filled slot, then the allocation step writes the tag and
// the result step loads the result register; a hit stops the scan early at
// the matching slot. Slots fill from zero upward, so a fill count stands in for
// the valid bits; once all slots are taken the round-robin pointer picks the victim.
// One item is in work at a time; in_ready is high only while the sequencer
// is idle. The result register holds a finished result while the receiver
// stalls, and a new item may be taken meanwhile; it then waits in the result
// step until the register frees up.
// Reset empties the cache (fill count zero), clears the pointer and sets
// sectors per block to 4. No clearing pass is needed.
module block_cache_slot_allocator import bcsa_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BLOCK_W-1:0]  in_block_number,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W_O-1:0] out_slot_index,
  output logic                out_hit,
  output logic [SECTOR_W-1:0] out_fetch_sector,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SPB_W-1:0]    cfg_data
);

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int MUL_W  = TAG_BITS + SPB_W;

  state_t              state_r, state_nxt;
  logic [SPB_W-1:0]    spb_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [CNT_W-1:0]    fill_r;
  logic [SLOT_W-1:0]   ptr_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                hit_r;
  logic [MUL_W-1:0]    prod_r;
  logic                out_valid_r;
  logic                full;
  logic [SLOT_W-1:0]   target;
  logic                in_xfer;
  logic                out_free;
  scan_stat_t          scan_stat;
  logic [SLOT_W-1:0]   match_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Take the lowest free slot while the cache fills, else the round-robin victim.
  assign full   = (fill_r == CNT_W'(ENTRIES));
  assign target = full ? ptr_r : fill_r[SLOT_W-1:0];

  bcsa_tag_scan #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .tag       (tag_r),
    .fill      (fill_r),
    .wr_en     (state_r == S_ALLOC),
    .wr_addr   (target),
    .stat      (scan_stat),
    .match_idx (match_idx)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_stat.done) state_nxt = scan_stat.hit ? S_RESULT : S_ALLOC;
      end
      S_ALLOC: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spb_r       <= SPB_RESET;
      fill_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        spb_r <= cfg_data;
      end
      if (state_r == S_ALLOC) begin
        if (full) begin
          ptr_r <= (ptr_r == SLOT_W'(ENTRIES - 1)) ? '0 : ptr_r + 1'b1;
        end else begin
          fill_r <= fill_r + 1'b1;
        end
      end
      // Hold the result until the receiver takes it.
      if (state_r == S_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tag_r <= TAG_BITS'(in_block_number);
    end
    if (state_r == S_SCAN && scan_stat.done) begin
      slot_r <= match_idx;
      hit_r  <= scan_stat.hit;
    end
    if (state_r == S_ALLOC) begin
      slot_r <= target;
      prod_r <= MUL_W'(tag_r) * MUL_W'(spb_r);
    end
    if (state_r == S_RESULT && out_free) begin
      out_slot_index   <= SLOT_W_O'(slot_r);
      out_hit          <= hit_r;
      out_fetch_sector <= hit_r ? '0 : SECTOR_W'(prod_r);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(ENTRIES))
    else $error("fill count beyond slot count");

  a_fill_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ALLOC) |=> $stable(fill_r))
    else $error("fill count moved outside allocation");

  a_ptr_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ALLOC || !full) |=> $stable(ptr_r))
    else $error("replace pointer moved while free slots remain");

  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_stat.done |-> (state_r == S_SCAN))
    else $error("lookup finished outside scan step");

endmodule
